/* rtl/swmp_pkg.sv */
// shared constants, types and register codes of the sliding window mean power block
package swmp_pkg;

    // ring geometry and sample format
    localparam int MAX_WINDOW  = 32768;
    localparam int SAMPLE_BITS = 24;
    localparam int PTR_W       = $clog2(MAX_WINDOW);
    localparam int CNT_W       = $clog2(MAX_WINDOW + 1);

    // datapath widths
    localparam int MAG_W   = SAMPLE_BITS;
    localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
    localparam int ABS_W   = SAMPLE_BITS + PTR_W;
    localparam int SUM_W   = 63;
    localparam int MEAN_W  = 47;
    localparam int STEP_W  = $clog2(SUM_W + 1);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOP_LEN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_MODE  = 2'd2;

    localparam logic [CFG_DATA_W-1:0] WINDOW_LEN_RST = 16'd19200;
    localparam logic [CFG_DATA_W-1:0] HOP_LEN_RST    = 16'd4800;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OLD,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } t_state;

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

/* rtl/swmp_div.sv */
// bit-serial restoring divider, one quotient bit per cycle
module swmp_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swmp_pkg::t_div_req i_req,
    output swmp_pkg::t_div_rsp o_rsp
);

    logic                         r_busy;
    logic                         r_done;
    logic [swmp_pkg::STEP_W-1:0]  r_steps;
    logic [swmp_pkg::CNT_W-1:0]   r_rem;
    logic [swmp_pkg::CNT_W-1:0]   r_divisor;
    logic [swmp_pkg::SUM_W-1:0]   r_quo;

    logic [swmp_pkg::CNT_W:0]     trial;
    logic                         q_bit;
    logic [swmp_pkg::CNT_W-1:0]   n_rem;

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
        trial = {r_rem, r_quo[swmp_pkg::SUM_W-1]};
        q_bit = (trial >= {1'b0, r_divisor});
        if (q_bit) begin
            n_rem = swmp_pkg::CNT_W'(trial - {1'b0, r_divisor});
        end else begin
            n_rem = trial[swmp_pkg::CNT_W-1:0];
        end
    end

    // control: busy flag, step count and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_steps <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_steps <= swmp_pkg::STEP_W'(swmp_pkg::SUM_W);
            end else if (r_busy) begin
                r_steps <= r_steps - 1'b1;
                if (r_steps == swmp_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend shifts out as quotient shifts in
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem     <= '0;
            r_divisor <= i_req.divisor;
            r_quo     <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[swmp_pkg::SUM_W-2:0], q_bit};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    // assertions
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !$past(i_req.start) |-> r_rem < r_divisor)
        else $error("divider remainder not below divisor");

endmodule

/* rtl/sliding_window_mean_power.sv */
// sliding window mean power: sample ring, running sums and result sequencer
//
// Usage: signed samples arrive on the sample channel (valid/ready); every
// hop_len samples one beat leaves on the result channel carrying the window
// mean (squares or absolute values, per mean_mode) and a window_full flag.
// Until window_len samples are held the beat carries zero with window_full
// clear. The user must write registers through the plain write port only
// while idle; the block itself does not enforce it. Sequence: an item
// that gives no result passes accept, ring read and sum update; a result
// before the window fills adds the output state. A full window mean runs
// the bit-serial divider, which produces one of 63 quotient bits per
// cycle, then the output state loads the output register. The
// single-port-per-direction ring is read and written in the accept cycle.
// Reset (synchronous, active low) empties the window, zeroes both sums and
// the hop counter and restores register defaults; no clearing pass is
// needed, ring read data is only used at held entries.
// A stalled receiver holds the result beat in the output register; the
// next item is still taken and worked on, and the block waits only when a
// second result is ready before the first has gone.
module sliding_window_mean_power (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [swmp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [swmp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_sample_valid,
    output logic                                o_sample_ready,
    input  logic signed [swmp_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic                                o_result_valid,
    input  logic                                i_result_ready,
    output logic [swmp_pkg::MEAN_W-1:0]         o_mean_value,
    output logic                                o_window_full
);

    // configuration registers
    logic [swmp_pkg::CFG_DATA_W-1:0] r_window_len;
    logic [swmp_pkg::CFG_DATA_W-1:0] r_hop_len;
    logic                            r_mean_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= swmp_pkg::WINDOW_LEN_RST;
            r_hop_len    <= swmp_pkg::HOP_LEN_RST;
            r_mean_mode  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                swmp_pkg::REG_WINDOW_LEN: r_window_len <= i_cfg_data;
                swmp_pkg::REG_HOP_LEN:    r_hop_len    <= i_cfg_data;
                swmp_pkg::REG_MEAN_MODE:  r_mean_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective window: zero acts as one, saturates at the ring depth
    logic [swmp_pkg::CNT_W-1:0] eff_w;

    always_comb begin
        if (r_window_len == '0) begin
            eff_w = swmp_pkg::CNT_W'(1);
        end else if (32'(r_window_len) > 32'(swmp_pkg::MAX_WINDOW)) begin
            eff_w = swmp_pkg::CNT_W'(swmp_pkg::MAX_WINDOW);
        end else begin
            eff_w = swmp_pkg::CNT_W'(r_window_len);
        end
    end

    // state
    swmp_pkg::t_state r_state;
    swmp_pkg::t_state n_state;

    logic [swmp_pkg::PTR_W-1:0] r_wp;
    logic [swmp_pkg::CNT_W-1:0] r_fill;
    logic [swmp_pkg::SUM_W-1:0] r_sum;
    logic [swmp_pkg::ABS_W-1:0] r_abs;
    logic [swmp_pkg::CFG_DATA_W-1:0] r_hop;

    logic                       r_drop;
    logic [swmp_pkg::MAG_W-1:0] r_new_mag;
    logic [swmp_pkg::SQ_W-1:0]  r_new_sq;
    logic [swmp_pkg::MAG_W-1:0] r_old_mag;
    logic [swmp_pkg::SQ_W-1:0]  r_old_sq;
    logic [swmp_pkg::SAMPLE_BITS-1:0] r_rd_data;

    logic [swmp_pkg::MEAN_W-1:0] r_res_mean;
    logic                        r_res_full;

    logic                        r_out_valid;
    logic [swmp_pkg::MEAN_W-1:0] r_out_mean;
    logic                        r_out_full;

    // handshake and control strobes
    logic in_acc;
    logic out_free;
    logic load_out;
    logic div_start;

    swmp_pkg::t_div_req div_req;
    swmp_pkg::t_div_rsp div_rsp;

    assign out_free = !r_out_valid || i_result_ready;
    assign in_acc   = i_sample_valid && o_sample_ready;

    // new sample magnitude and square
    logic [swmp_pkg::MAG_W-1:0]   new_mag;
    logic [2*swmp_pkg::MAG_W-1:0] new_prod;

    always_comb begin
        if (i_sample[swmp_pkg::SAMPLE_BITS-1]) begin
            new_mag = ~i_sample + 1'b1;
        end else begin
            new_mag = i_sample;
        end
        new_prod = new_mag * new_mag;
    end

    // oldest held slot, wrapping round the ring
    logic [swmp_pkg::CNT_W:0]   idx_sum;
    logic [swmp_pkg::PTR_W-1:0] old_idx;
    logic [swmp_pkg::PTR_W-1:0] wp_next;

    always_comb begin
        idx_sum = (swmp_pkg::CNT_W+1)'(r_wp) + (swmp_pkg::CNT_W+1)'(swmp_pkg::MAX_WINDOW)
                  - (swmp_pkg::CNT_W+1)'(r_fill);
        if (idx_sum >= (swmp_pkg::CNT_W+1)'(swmp_pkg::MAX_WINDOW)) begin
            idx_sum = idx_sum - (swmp_pkg::CNT_W+1)'(swmp_pkg::MAX_WINDOW);
        end
        old_idx = idx_sum[swmp_pkg::PTR_W-1:0];
        if (32'(r_wp) == swmp_pkg::MAX_WINDOW - 1) begin
            wp_next = '0;
        end else begin
            wp_next = r_wp + 1'b1;
        end
    end

    // sample ring: read-first, so a full ring returns the slot being overwritten
    logic [swmp_pkg::SAMPLE_BITS-1:0] ring [swmp_pkg::MAX_WINDOW];

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            ring[r_wp] <= i_sample;
            r_rd_data  <= ring[old_idx];
        end
    end

    // dropped sample magnitude and square
    logic [swmp_pkg::MAG_W-1:0]   old_mag;
    logic [2*swmp_pkg::MAG_W-1:0] old_prod;

    always_comb begin
        if (!r_drop) begin
            old_mag = '0;
        end else if (r_rd_data[swmp_pkg::SAMPLE_BITS-1]) begin
            old_mag = ~r_rd_data + 1'b1;
        end else begin
            old_mag = r_rd_data;
        end
        old_prod = old_mag * old_mag;
    end

    // sum, fill and hop update
    logic [swmp_pkg::SUM_W-1:0]      n_sum;
    logic [swmp_pkg::ABS_W-1:0]      n_abs;
    logic [swmp_pkg::CNT_W-1:0]      n_fill;
    logic [swmp_pkg::CFG_DATA_W-1:0] n_hop;
    logic                            emit;
    logic                            full;

    always_comb begin
        n_sum  = r_sum + swmp_pkg::SUM_W'(r_new_sq) - swmp_pkg::SUM_W'(r_old_sq);
        n_abs  = r_abs + swmp_pkg::ABS_W'(r_new_mag) - swmp_pkg::ABS_W'(r_old_mag);
        n_fill = r_fill + 1'b1 - swmp_pkg::CNT_W'(r_drop);
        n_hop  = r_hop + 1'b1;
        emit   = !(n_hop < r_hop_len);
        full   = (n_fill >= eff_w);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            swmp_pkg::ST_IDLE: begin
                if (in_acc) n_state = swmp_pkg::ST_OLD;
            end
            swmp_pkg::ST_OLD: n_state = swmp_pkg::ST_SUM;
            swmp_pkg::ST_SUM: begin
                if (!emit) begin
                    n_state = swmp_pkg::ST_IDLE;
                end else if (full) begin
                    n_state = swmp_pkg::ST_DIV;
                end else begin
                    n_state = swmp_pkg::ST_OUT;
                end
            end
            swmp_pkg::ST_DIV: begin
                if (div_rsp.done) n_state = swmp_pkg::ST_OUT;
            end
            swmp_pkg::ST_OUT: begin
                if (out_free) n_state = swmp_pkg::ST_IDLE;
            end
            default: n_state = swmp_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_sample_ready = 1'b0;
        load_out       = 1'b0;
        div_start      = 1'b0;
        case (r_state)
            swmp_pkg::ST_IDLE: o_sample_ready = 1'b1;
            swmp_pkg::ST_SUM:  div_start      = emit && full;
            swmp_pkg::ST_OUT:  load_out       = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swmp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // window bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
            r_sum  <= '0;
            r_abs  <= '0;
            r_hop  <= '0;
        end else begin
            if (in_acc) begin
                r_wp <= wp_next;
            end
            if (r_state == swmp_pkg::ST_SUM) begin
                r_fill <= n_fill;
                r_sum  <= n_sum;
                r_abs  <= n_abs;
                r_hop  <= emit ? '0 : n_hop;
            end
        end
    end

    // per-item pipeline registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_drop    <= (r_fill >= eff_w);
            r_new_mag <= new_mag;
            r_new_sq  <= new_prod[swmp_pkg::SQ_W-1:0];
        end
        if (r_state == swmp_pkg::ST_OLD) begin
            r_old_mag <= old_mag;
            r_old_sq  <= old_prod[swmp_pkg::SQ_W-1:0];
        end
    end

    // divider
    assign div_req.start    = div_start;
    assign div_req.dividend = r_mean_mode ? swmp_pkg::SUM_W'(n_abs) : n_sum;
    assign div_req.divisor  = eff_w;

    swmp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // pending result, saturated to the mean field
    always_ff @(posedge i_clk) begin
        if (r_state == swmp_pkg::ST_SUM) begin
            r_res_mean <= '0;
            r_res_full <= 1'b0;
        end else if (r_state == swmp_pkg::ST_DIV && div_rsp.done) begin
            r_res_full <= 1'b1;
            if (|div_rsp.quotient[swmp_pkg::SUM_W-1:swmp_pkg::MEAN_W]) begin
                r_res_mean <= '1;
            end else begin
                r_res_mean <= div_rsp.quotient[swmp_pkg::MEAN_W-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_result_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_mean <= r_res_mean;
            r_out_full <= r_res_full;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_mean_value   = r_out_mean;
    assign o_window_full  = r_out_full;

    // assertions
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= swmp_pkg::MAX_WINDOW)
        else $error("fill count beyond ring depth");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == swmp_pkg::ST_OLD)
        else $error("accepted beat not followed by ring read");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> r_state == swmp_pkg::ST_DIV)
        else $error("divider finished outside the divide state");

    a_empty_mean_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_window_full |-> o_mean_value == '0)
        else $error("non-zero mean before the window filled");

endmodule
